@@ hw/rtl/keyed_object_table_upsert_advance_assert.svh @@
// Assertion macros used by the checker file.
`ifndef KEYED_OBJECT_TABLE_UPSERT_ADVANCE_ASSERT_SVH
`define KEYED_OBJECT_TABLE_UPSERT_ADVANCE_ASSERT_SVH

// Implication checked at every edge outside reset.
`define KOT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Implication checked in the cycle after the antecedent.
`define KOT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ hw/rtl/kot_pkg.sv @@
`default_nettype none
package kot_pkg;
	localparam int unsigned CfgIdxW = 1;
	localparam int unsigned CfgDataW = 15;
	localparam logic [CfgIdxW-1:0] RegMapWidth = 1'd0;
	localparam logic [CfgIdxW-1:0] RegMapHeight = 1'd1;

	localparam logic [1:0] ActUpsert = 2'd0;
	localparam logic [1:0] ActTick = 2'd1;
	localparam logic [1:0] ActClear = 2'd2;
	localparam logic [1:0] ActList = 2'd3;

	localparam logic [3:0] StUpdated = 4'd0;
	localparam logic [3:0] StRetired = 4'd1;
	localparam logic [3:0] StInserted = 4'd2;
	localparam logic [3:0] StIgnored = 4'd3;
	localparam logic [3:0] StFull = 4'd4;
	localparam logic [3:0] StTicked = 4'd5;
	localparam logic [3:0] StCleared = 4'd6;
	localparam logic [3:0] StListEntry = 4'd7;
	localparam logic [3:0] StListEmpty = 4'd8;

	typedef struct packed {
		logic [1:0] action;
		logic [31:0] object_key;
		logic [15:0] owner;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic [15:0] speed;
		logic keep_active;
		logic [15:0] tick_time;
	} in_word_t;

	typedef struct packed {
		logic [3:0] status;
		logic [6:0] valid_count;
		logic [31:0] out_key;
		logic [15:0] out_owner;
		logic signed [23:0] out_x;
		logic signed [23:0] out_y;
		logic signed [15:0] out_dir_x;
		logic signed [15:0] out_dir_y;
		logic [15:0] out_speed;
		logic last;
	} out_word_t;

	// one stored table entry
	typedef struct packed {
		logic [31:0] key;
		logic [15:0] owner;
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic [15:0] speed;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic rd_en;       // read entry at scan index
		logic wr_new;      // write input fields at target slot
		logic set_valid;   // valid of target slot := keep
		logic mul_start;   // start the advance arithmetic on the read entry
		logic tick_wr;     // write advanced position, retire check
		logic clear_all;
		logic out_load;    // copy read entry into the list output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic cur_valid;   // valid bit at scan index
		logic key_hit;     // registered read key equals input key
		logic adv_done;
	} stat_t;
endpackage
`default_nettype wire

@@ hw/rtl/keyed_object_table_upsert_advance.sv @@
`default_nettype none
// Keyed object table with upsert, tick, clear and list actions.
// Input channel: in_valid/in_ready carry one in_word_t; it is taken only
// while the block is idle, one item at a time.
// Output channel: out_valid/out_ready carry out_word_t results; the final
// result of an item has last set. List gives one word per valid slot, or a
// single list-empty word.
// Upsert and list scan the slots in order; tick runs each valid slot through the
// shared advance unit (two multiplies per axis); clear does not scan.
// The output register holds a word until out_ready. A list scan runs ahead to
// the next valid slot and waits there; every other action stops in its last
// state, so a stall on the output stalls the whole block.
// Reset: all slots invalid, map box 800 by 600, no clearing pass needed since
// valid bits sit in flip-flops.
// Config: cfg_we/cfg_idx/cfg_data write the map box width (index 0) or
// height (index 1) while idle; the block itself does not enforce this.
module keyed_object_table_upsert_advance #(
	parameter int unsigned TABLE_DEPTH = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire kot_pkg::in_word_t in_data,
	output logic out_valid,
	input  wire logic out_ready,
	output kot_pkg::out_word_t out_data,
	input  wire logic cfg_we,
	input  wire logic [kot_pkg::CfgIdxW-1:0] cfg_idx,
	input  wire logic [kot_pkg::CfgDataW-1:0] cfg_data
);
	import kot_pkg::*;
	localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	logic [14:0] map_w_q, map_h_q;
	cmd_t cmd;
	stat_t stat;
	logic [IdxW-1:0] scan_idx, tgt_idx;
	entry_t rd_entry;
	logic [6:0] count;
	logic [3:0] status;
	logic last, is_list;
	in_word_t item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_w_q <= 15'd800;
			map_h_q <= 15'd600;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				RegMapWidth: map_w_q <= cfg_data;
				default: map_h_q <= cfg_data;
			endcase
		end
	end

	// hold the word for the whole item
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) item_q <= in_data;
	end

	kot_ctrl #(.Depth(TABLE_DEPTH), .IdxW(IdxW)) u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready,
		.action(in_data.action), .keep(in_data.keep_active), .valid_count(count),
		.out_valid, .out_ready, .out_status(status), .out_last(last),
		.out_list(is_list), .cmd, .stat, .scan_idx, .tgt_idx
	);

	// rd_entry is the registered listed entry, loaded when a list word launches
	kot_datapath #(.Depth(TABLE_DEPTH), .IdxW(IdxW)) u_dp (
		.clk, .arst_n, .cmd, .stat, .scan_idx, .tgt_idx, .item(item_q),
		.map_w(map_w_q), .map_h(map_h_q), .rd_entry, .count
	);

	always_comb begin
		out_data = '0;
		out_data.status = status;
		out_data.valid_count = count;
		out_data.last = last;
		if (is_list) begin
			out_data.out_key = rd_entry.key;
			out_data.out_owner = rd_entry.owner;
			out_data.out_x = rd_entry.x;
			out_data.out_y = rd_entry.y;
			out_data.out_dir_x = rd_entry.dir_x;
			out_data.out_dir_y = rd_entry.dir_y;
			out_data.out_speed = rd_entry.speed;
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/kot_datapath.sv @@
`default_nettype none
module kot_datapath #(
	parameter int unsigned Depth = 64,
	parameter int unsigned IdxW = 6
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire kot_pkg::cmd_t cmd,
	output kot_pkg::stat_t stat,
	input  wire logic [IdxW-1:0] scan_idx,
	input  wire logic [IdxW-1:0] tgt_idx,
	input  wire kot_pkg::in_word_t item,
	input  wire logic [14:0] map_w,
	input  wire logic [14:0] map_h,
	output kot_pkg::entry_t rd_entry,
	output logic [6:0] count
);
	import kot_pkg::*;

	entry_t mem_q [Depth];
	logic [Depth-1:0] valid_q;
	entry_t rd_q;
	entry_t out_q;
	logic [IdxW-1:0] rd_idx_q;

	// advance unit: one axis per pass, two multiplies per axis
	logic [2:0] step_q;
	logic signed [31:0] ds_q;
	logic signed [48:0] prod_q;
	logic signed [23:0] nx_q, ny_q;
	logic signed [23:0] pos_sel;
	logic signed [15:0] dir_sel;
	logic signed [49:0] rnd;
	logic signed [24:0] np;
	logic signed [23:0] sat;

	always_comb begin
		pos_sel = step_q[2] ? rd_q.y : rd_q.x;
		dir_sel = step_q[2] ? rd_q.dir_y : rd_q.dir_x;
		rnd = {prod_q[48], prod_q} + 50'sd33554432;
		// arithmetic shift floors; result fits in 25 bits
		np = 25'(signed'(rnd >>> 26)) + 25'(pos_sel);
		if (np > 25'sd8388607) sat = 24'sd8388607;
		else if (np < -25'sd8388608) sat = -24'sd8388608;
		else sat = np[23:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 3'd0;
		end else if (cmd.mul_start) begin
			step_q <= 3'd1;
		end else if (step_q != 3'd0) begin
			step_q <= (step_q == 3'd6) ? 3'd0 : step_q + 3'd1;
		end
	end

	// step 1,4: dir*speed; 2,5: *time; 3,6: round and saturate
	always_ff @(posedge clk) begin
		unique case (step_q)
			3'd1, 3'd4: ds_q <= 32'(dir_sel) * signed'({1'b0, rd_q.speed});
			3'd2, 3'd5: prod_q <= 49'(ds_q) * signed'({1'b0, item.tick_time});
			3'd3: nx_q <= sat;
			3'd6: ny_q <= sat;
			default: ;
		endcase
	end
	// step_q[2] selects the y axis from step 4 on
	assign stat.adv_done = (step_q == 3'd0);

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_q <= mem_q[scan_idx];
			rd_idx_q <= scan_idx;
		end
		if (cmd.wr_new) begin
			mem_q[tgt_idx] <= '{item.object_key, item.owner, item.pos_x, item.pos_y,
				item.dir_x, item.dir_y, item.speed};
		end else if (cmd.tick_wr) begin
			mem_q[rd_idx_q] <= '{rd_q.key, rd_q.owner, nx_q, ny_q,
				rd_q.dir_x, rd_q.dir_y, rd_q.speed};
		end
	end

	// hold the listed entry while its word waits on the output
	always_ff @(posedge clk) begin
		if (cmd.out_load) out_q <= rd_q;
	end

	logic out_box;
	assign out_box = nx_q < 0 || ny_q < 0 || nx_q > signed'({1'b0, map_w, 8'd0})
		|| ny_q > signed'({1'b0, map_h, 8'd0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.clear_all) begin
			valid_q <= '0;
		end else if (cmd.set_valid) begin
			valid_q[tgt_idx] <= item.keep_active;
		end else if (cmd.tick_wr && out_box) begin
			valid_q[rd_idx_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count <= '0;
		end else begin
			count <= 7'($countones(valid_q));
		end
	end

	assign stat.cur_valid = valid_q[scan_idx];
	assign stat.key_hit = (rd_q.key == item.object_key);
	assign rd_entry = out_q;
endmodule
`default_nettype wire

@@ hw/rtl/kot_ctrl.sv @@
`default_nettype none
module kot_ctrl #(
	parameter int unsigned Depth = 64,
	parameter int unsigned IdxW = 6
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [1:0] action,
	input  wire logic keep,
	input  wire logic [6:0] valid_count,
	output logic out_valid,
	input  wire logic out_ready,
	output logic [3:0] out_status,
	output logic out_last,
	output logic out_list,
	output kot_pkg::cmd_t cmd,
	input  wire kot_pkg::stat_t stat,
	output logic [IdxW-1:0] scan_idx,
	output logic [IdxW-1:0] tgt_idx
);
	import kot_pkg::*;

	typedef enum logic [3:0] {
		IDLE, UP_SCAN, UP_CMP, UP_WR, TK_SCAN, TK_RD, TK_MUL, TK_WAIT, TK_WR,
		LS_SCAN, LS_RD, LS_OUT, SETTLE, EMIT
	} state_t;

	state_t state_q;
	logic free_q, keep_q;
	logic [IdxW-1:0] free_idx_q;
	logic [3:0] status_q;
	logic [6:0] sent_q;
	logic at_end;
	logic list_launch;
	localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);

	assign at_end = (scan_idx == LastIdx);
	assign in_ready = (state_q == IDLE);
	assign out_status = status_q;
	// launch a list word once the output register is free
	assign list_launch = (state_q == LS_OUT) && (!out_valid || out_ready);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			UP_SCAN: cmd.rd_en = stat.cur_valid;
			UP_WR: begin
				cmd.wr_new = 1'b1;
				cmd.set_valid = 1'b1;
			end
			TK_SCAN: cmd.rd_en = stat.cur_valid;
			TK_RD: cmd.mul_start = 1'b1;
			TK_WR: cmd.tick_wr = 1'b1;
			LS_SCAN: cmd.rd_en = stat.cur_valid;
			default: ;
		endcase
		cmd.out_load = list_launch;
		if (state_q == IDLE && in_valid && action == ActClear) cmd.clear_all = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			scan_idx <= '0;
			tgt_idx <= '0;
			free_idx_q <= '0;
			free_q <= 1'b0;
			keep_q <= 1'b0;
			status_q <= StUpdated;
			sent_q <= '0;
			out_valid <= 1'b0;
			out_last <= 1'b0;
			out_list <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: if (in_valid) begin
					keep_q <= keep;
					scan_idx <= '0;
					free_q <= 1'b0;
					sent_q <= '0;
					unique case (action)
						ActUpsert: state_q <= UP_SCAN;
						ActTick: state_q <= TK_SCAN;
						ActClear: begin
							status_q <= StCleared;
							state_q <= SETTLE;
						end
						default: begin
							if (valid_count == 7'd0) begin
								status_q <= StListEmpty;
								state_q <= SETTLE;
							end else begin
								state_q <= LS_SCAN;
							end
						end
					endcase
				end
				UP_SCAN: begin
					if (stat.cur_valid) begin
						state_q <= UP_CMP;
					end else begin
						if (!free_q) begin
							free_q <= 1'b1;
							free_idx_q <= scan_idx;
						end
						if (at_end) begin
							if (keep_q && (free_q || 1'b1)) begin
								tgt_idx <= free_q ? free_idx_q : scan_idx;
								status_q <= StInserted;
								state_q <= UP_WR;
							end else begin
								status_q <= StIgnored;
								state_q <= SETTLE;
							end
						end else begin
							scan_idx <= scan_idx + 1'b1;
						end
					end
				end
				UP_CMP: begin
					if (stat.key_hit) begin
						tgt_idx <= scan_idx;
						status_q <= keep_q ? StUpdated : StRetired;
						state_q <= UP_WR;
					end else if (at_end) begin
						if (keep_q && free_q) begin
							tgt_idx <= free_idx_q;
							status_q <= StInserted;
							state_q <= UP_WR;
						end else begin
							status_q <= keep_q ? StFull : StIgnored;
							state_q <= SETTLE;
						end
					end else begin
						scan_idx <= scan_idx + 1'b1;
						state_q <= UP_SCAN;
					end
				end
				UP_WR: state_q <= SETTLE;
				TK_SCAN: begin
					if (stat.cur_valid) state_q <= TK_RD;
					else if (at_end) begin
						status_q <= StTicked;
						state_q <= SETTLE;
					end else scan_idx <= scan_idx + 1'b1;
				end
				TK_RD: state_q <= TK_MUL;
				TK_MUL: state_q <= TK_WAIT;
				TK_WAIT: if (stat.adv_done) state_q <= TK_WR;
				TK_WR: begin
					if (at_end) begin
						status_q <= StTicked;
						state_q <= SETTLE;
					end else begin
						scan_idx <= scan_idx + 1'b1;
						state_q <= TK_SCAN;
					end
				end
				LS_SCAN: begin
					// the valid count says more entries remain, so the scan finds one
					if (stat.cur_valid) state_q <= LS_RD;
					else scan_idx <= scan_idx + 1'b1;
				end
				LS_RD: begin
					// read data lands in the datapath this cycle
					state_q <= LS_OUT;
				end
				LS_OUT: if (list_launch) begin
					out_valid <= 1'b1;
					out_list <= 1'b1;
					status_q <= StListEntry;
					out_last <= ((sent_q + 7'd1) == valid_count);
					sent_q <= sent_q + 7'd1;
					if ((sent_q + 7'd1) == valid_count) begin
						state_q <= EMIT;
					end else begin
						scan_idx <= scan_idx + 1'b1;
						state_q <= LS_SCAN;
					end
				end
				SETTLE: begin
					out_valid <= 1'b1;
					out_last <= 1'b1;
					out_list <= 1'b0;
					state_q <= EMIT;
				end
				EMIT: if (out_valid && out_ready) begin
					out_valid <= 1'b0;
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
			if (out_valid && out_ready && state_q != EMIT && !(state_q == LS_OUT))
				out_valid <= 1'b0;
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/kot_checker.sv @@
`default_nettype none
`include "keyed_object_table_upsert_advance_assert.svh"
module kot_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire kot_pkg::out_word_t out_data
);
	import kot_pkg::*;
	`KOT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`KOT_ASSERT_IMP(a_busy, clk, arst_n, out_valid, !in_ready)
	`KOT_ASSERT_IMP(a_count, clk, arst_n, out_valid, out_data.valid_count <= 7'd64)
	`KOT_ASSERT_IMP(a_zero, clk, arst_n, out_valid && out_data.status != StListEntry, out_data.out_key == 32'd0 && out_data.last)
endmodule

bind keyed_object_table_upsert_advance kot_checker u_chk (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb;
	import kot_pkg::*;

	localparam int Depth = 64;
	// A cycle with no word moving on either channel counts against this. It covers
	// the longest item of its own, and the worst output stall as well.
	localparam int StallLimit = 20000;
	localparam int SettleCycles = 600;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_word_t in_data;
	logic out_valid;
	logic out_ready;
	out_word_t out_data;
	logic cfg_we;
	logic [CfgIdxW-1:0] cfg_idx;
	logic [CfgDataW-1:0] cfg_data;

	keyed_object_table_upsert_advance dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// Keep a local copy of the object table and the map box.
	logic table_valid [Depth];
	entry_t table_entry [Depth];
	logic [14:0] box_w, box_h;

	out_word_t pending_words[$];
	int errors;
	int in_idle_pct, out_idle_pct;
	int idle_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [6:0] live_count();
		int n;
		n = 0;
		for (int i = 0; i < Depth; i++) if (table_valid[i]) n++;
		return n[6:0];
	endfunction

	function automatic logic signed [23:0] step_axis(logic signed [23:0] p,
			logic signed [15:0] d, logic [15:0] s, logic [15:0] t);
		logic signed [63:0] prod, np;
		prod = 64'(d) * $signed({48'd0, s}) * $signed({48'd0, t});
		// round to Q16.8: add half then floor (arithmetic shift floors)
		np = 64'(p) + ((prod + (64'sd1 <<< 25)) >>> 26);
		if (np > 64'sd8388607) np = 64'sd8388607;
		if (np < -64'sd8388608) np = -64'sd8388608;
		return np[23:0];
	endfunction

	function automatic out_word_t plain_word(logic [3:0] st);
		out_word_t w;
		w = '0;
		w.status = st;
		w.valid_count = live_count();
		w.last = 1'b1;
		return w;
	endfunction

	// Apply one accepted word to the table copy and queue the words it yields.
	task automatic predict_table(input in_word_t w);
		int hit, open_slot, total, k;
		out_word_t r;
		logic signed [31:0] xmax, ymax;
		hit = -1; open_slot = -1;
		case (w.action)
			ActUpsert: begin
				for (int i = 0; i < Depth; i++) begin
					if (table_valid[i] && table_entry[i].key == w.object_key) begin
						hit = i;
						break;
					end
					if (!table_valid[i] && open_slot < 0) open_slot = i;
				end
				if (hit < 0 && w.keep_active && open_slot >= 0) hit = open_slot;
				if (hit >= 0) begin
					logic matched;
					matched = table_valid[hit];
					table_entry[hit] = '{w.object_key, w.owner, w.pos_x, w.pos_y,
						w.dir_x, w.dir_y, w.speed};
					table_valid[hit] = w.keep_active;
					pending_words.push_back(plain_word(!matched ? StInserted :
						(w.keep_active ? StUpdated : StRetired)));
				end else begin
					pending_words.push_back(plain_word(w.keep_active ? StFull : StIgnored));
				end
			end
			ActTick: begin
				xmax = {9'd0, box_w, 8'd0};
				ymax = {9'd0, box_h, 8'd0};
				for (int i = 0; i < Depth; i++) begin
					if (!table_valid[i]) continue;
					table_entry[i].x = step_axis(table_entry[i].x, table_entry[i].dir_x,
						table_entry[i].speed, w.tick_time);
					table_entry[i].y = step_axis(table_entry[i].y, table_entry[i].dir_y,
						table_entry[i].speed, w.tick_time);
					if (table_entry[i].x < 0 || table_entry[i].y < 0 ||
							32'(table_entry[i].x) > xmax || 32'(table_entry[i].y) > ymax)
						table_valid[i] = 1'b0;
				end
				pending_words.push_back(plain_word(StTicked));
			end
			ActClear: begin
				for (int i = 0; i < Depth; i++) table_valid[i] = 1'b0;
				pending_words.push_back(plain_word(StCleared));
			end
			default: begin
				total = live_count();
				k = 0;
				if (total == 0) pending_words.push_back(plain_word(StListEmpty));
				for (int i = 0; i < Depth; i++) begin
					if (!table_valid[i]) continue;
					k++;
					r.status = StListEntry;
					r.valid_count = total[6:0];
					r.out_key = table_entry[i].key;
					r.out_owner = table_entry[i].owner;
					r.out_x = table_entry[i].x;
					r.out_y = table_entry[i].y;
					r.out_dir_x = table_entry[i].dir_x;
					r.out_dir_y = table_entry[i].dir_y;
					r.out_speed = table_entry[i].speed;
					r.last = (k == total);
					pending_words.push_back(r);
				end
			end
		endcase
	endtask

	// Compare every accepted result word against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word %p", $time, out_data);
				errors++;
			end else begin
				out_word_t e;
				e = pending_words.pop_front();
				if (out_data.status !== e.status || out_data.valid_count !== e.valid_count ||
						out_data.out_key !== e.out_key || out_data.out_owner !== e.out_owner ||
						out_data.out_x !== e.out_x || out_data.out_y !== e.out_y ||
						out_data.out_dir_x !== e.out_dir_x ||
						out_data.out_dir_y !== e.out_dir_y ||
						out_data.out_speed !== e.out_speed || out_data.last !== e.last) begin
					$display("%0t: mismatch expected %p actual %p", $time, e, out_data);
					errors++;
				end
			end
		end
		if (arst_n && in_valid && in_ready) predict_table(in_data);
	end

	// Randomly drop ready on the result side.
	always @(negedge clk) begin
		if (!arst_n) out_ready <= 1'b0;
		else out_ready <= ($urandom_range(99) >= out_idle_pct);
	end

	// Watchdog: count cycles in which no word moves.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= StallLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Called at a falling edge; valid of the previous word is still up and is
	// either replaced at once or dropped for a random gap.
	task automatic send_word(input in_word_t w);
		if ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < in_idle_pct) @(negedge clk);
		end
		in_data <= w;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic write_box(input logic [14:0] w, input logic [14:0] h);
		cfg_we <= 1'b1;
		cfg_idx <= RegMapWidth;
		cfg_data <= w;
		@(negedge clk);
		cfg_idx <= RegMapHeight;
		cfg_data <= h;
		@(negedge clk);
		cfg_we <= 1'b0;
		box_w = w;
		box_h = h;
	endtask

	function automatic in_word_t make_word(logic [1:0] act, logic [31:0] key,
			logic signed [23:0] x, logic signed [23:0] y, logic signed [15:0] dx,
			logic signed [15:0] dy, logic [15:0] spd, logic keep, logic [15:0] t);
		in_word_t w;
		w.action = act;
		w.object_key = key;
		w.owner = 16'($urandom);
		w.pos_x = x;
		w.pos_y = y;
		w.dir_x = dx;
		w.dir_y = dy;
		w.speed = spd;
		w.keep_active = keep;
		w.tick_time = t;
		return w;
	endfunction

	function automatic logic signed [15:0] rand_dir();
		int r;
		r = $urandom_range(4);
		if (r == 0) return 16'sd16384;
		if (r == 1) return -16'sd16384;
		return 16'($signed($urandom_range(32768)) - 16384);
	endfunction

	// Mostly upserts on a small key pool so matches, retires and full tables happen.
	function automatic in_word_t rand_word(int key_pool);
		int r;
		logic [1:0] act;
		logic signed [23:0] x, y;
		r = $urandom_range(99);
		act = r < 60 ? ActUpsert : r < 82 ? ActTick : r < 86 ? ActClear : ActList;
		if ($urandom_range(9) == 0) begin
			x = 24'($urandom);
			y = 24'($urandom);
		end else begin
			x = 24'($urandom_range({box_w, 8'd0}));
			y = 24'($urandom_range({box_h, 8'd0}));
		end
		return make_word(act, ($urandom_range(9) == 0) ? $urandom : $urandom_range(key_pool),
			x, y, rand_dir(), rand_dir(),
			($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(800)),
			$urandom_range(5) != 0,
			($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2000)));
	endfunction

	typedef struct {
		in_word_t w;
		logic check_fixed;
		logic [3:0] fixed_status;
	} directed_row_t;

	directed_row_t directed_rows[$];

	initial begin
		in_word_t w;
		errors = 0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_idx = RegMapWidth;
		cfg_data = '0;
		out_ready = 1'b0;
		in_idle_pct = 11;
		out_idle_pct = 79;
		idle_cycles = 0;
		box_w = 15'd800;
		box_h = 15'd600;
		for (int i = 0; i < Depth; i++) begin
			table_valid[i] = 1'b0;
			table_entry[i] = '0;
		end
		arst_n = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Directed table: fixed status where obvious, predictor for the rest.
		directed_rows = '{
			'{make_word(ActList, 0, 0, 0, 0, 0, 0, 0, 0), 1, StListEmpty},
			'{make_word(ActTick, 0, 0, 0, 0, 0, 0, 0, 16'hffff), 1, StTicked},
			'{make_word(ActUpsert, 32'h5, 0, 0, 0, 0, 0, 0, 0), 1, StIgnored},
			'{make_word(ActUpsert, 32'hffffffff, 24'sd204800, 24'sd153600, 16'sd16384,
				-16'sd16384, 16'hffff, 1, 16'hffff), 1, StInserted},
			'{make_word(ActUpsert, 32'h0, 0, 0, -16'sd16384, 16'sd16384, 16'h0, 1, 0),
				1, StInserted},
			'{make_word(ActUpsert, 32'h1, 24'sd100, 24'sd100, 16'sd100, 16'sd200,
				16'd160, 1, 0), 1, StInserted},
			'{make_word(ActUpsert, 32'h0, 24'sd8388607, -24'sd8388608, 16'sd16384,
				16'sd16384, 16'hffff, 1, 0), 1, StUpdated},
			'{make_word(ActList, 0, 0, 0, 0, 0, 0, 0, 0), 0, StListEntry},
			'{make_word(ActTick, 0, 0, 0, 0, 0, 0, 0, 16'd0), 0, StTicked},
			'{make_word(ActList, 0, 0, 0, 0, 0, 0, 0, 0), 0, StListEntry},
			'{make_word(ActUpsert, 32'h1, 0, 0, 0, 0, 0, 0, 0), 1, StRetired},
			'{make_word(ActUpsert, 32'h7, 24'sd1000, 24'sd1000, 16'sd16384, 16'sd0,
				16'd16, 1, 0), 1, StInserted},
			'{make_word(ActTick, 0, 0, 0, 0, 0, 0, 0, 16'hffff), 0, StTicked},
			'{make_word(ActList, 0, 0, 0, 0, 0, 0, 0, 0), 0, StListEntry},
			'{make_word(ActClear, 0, 0, 0, 0, 0, 0, 0, 0), 1, StCleared},
			'{make_word(ActList, 0, 0, 0, 0, 0, 0, 0, 0), 1, StListEmpty}
		};
		foreach (directed_rows[i]) begin
			send_word(directed_rows[i].w);
			if (directed_rows[i].check_fixed && pending_words.size() != 0 &&
					pending_words[$].status !== directed_rows[i].fixed_status) begin
				$display("%0t: mismatch expected %0d actual %0d", $time,
					directed_rows[i].fixed_status, pending_words[$].status);
				errors++;
			end
		end
		// fill every slot, then one more upsert drops for a full table
		for (int i = 0; i < Depth; i++)
			send_word(make_word(ActUpsert, 32'h100 + i, 24'sd256, 24'sd256, 0, 0, 0, 1, 0));
		send_word(make_word(ActUpsert, 32'h999, 0, 0, 0, 0, 0, 1, 0));
		if (pending_words[$].status !== StFull) begin
			$display("%0t: mismatch expected %0d actual %0d", $time, StFull,
				pending_words[$].status);
			errors++;
		end
		send_word(make_word(ActList, 0, 0, 0, 0, 0, 0, 0, 0));
		send_word(make_word(ActClear, 0, 0, 0, 0, 0, 0, 0, 0));
		drain_results();

		// Random phases over several map boxes, extremes included.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: write_box(15'd0, 15'd0);
				1: write_box(15'h7fff, 15'h7fff);
				2: write_box(15'd40, 15'd30);
				3: begin
					write_box(15'd800, 15'd600);
					in_idle_pct = 79;
					out_idle_pct = 11;
				end
				default: begin
					write_box(15'($urandom_range(2000)), 15'($urandom_range(2000)));
					in_idle_pct = 0;
					out_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < 36; n++) begin
				w = rand_word(ph == 1 ? 80 : 24);
				send_word(w);
			end
			send_word(make_word(ActList, 0, 0, 0, 0, 0, 0, 0, 0));
			drain_results();
		end

		if (errors == 0 && pending_words.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
